### sv/dsp_pkg.sv
package dsp_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int MAX_DEGREE_DEF   = 8;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam int VW     = 6;
  localparam int STW    = 3;
  localparam int VCW    = 7;
  localparam int PARW   = 7;
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;

  localparam logic [PARW-1:0] PARENT_NONE    = 7'd127;
  localparam logic            REG_VERTEX_CNT = 1'b0;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [STW-1:0] {
    ST_LOAD_OK  = 3'd0,
    ST_DROPPED  = 3'd1,
    ST_PATH     = 3'd2,
    ST_REJECTED = 3'd3,
    ST_CLEARED  = 3'd4
  } status_t;

  typedef struct packed {
    logic [VW-1:0]  vertex;
    logic [STW-1:0] status;
    logic           last;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE,
    L_DEGA,
    L_DEGB,
    L_DEGW,
    L_SCAN,
    L_SCANW,
    L_CHECK,
    L_UPD,
    L_SHR,
    L_SHW,
    L_PUT,
    L_RES,
    C_RES,
    Q_REJ,
    Q_INIT,
    Q_POP,
    Q_POPW,
    Q_CLOSE,
    Q_NB,
    Q_NBW,
    Q_REL,
    R_RD,
    R_W,
    I_RD,
    I_W,
    P_RD,
    P_EMIT
  } fsm_t;

endpackage

### sv/dijkstra_shortest_path.sv
// Load: one result word.
// Clear and rejected query: one result word.
// Query: each popped vertex has its neighbors read and relaxed, and open-list entries
// are moved by a remove or sorted insert; then path words are emitted. All loops
// run on single-port reads of the adjacency, node and open-list memories.
// One item at a time. Reset clears control, degree and node valid bits, vertex_count.
module dijkstra_shortest_path
  import dsp_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_DEGREE   = MAX_DEGREE_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_req_type,
  input  logic [VW-1:0]     in_vertex_a,
  input  logic [VW-1:0]     in_vertex_b,
  input  logic [15:0]       in_edge_weight,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [VW-1:0]     out_path_vertex,
  output logic [STW-1:0]    out_status,
  output logic              out_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int DB     = WEIGHT_BITS + 6;
  localparam int VA     = $clog2(MAX_VERTICES);
  localparam int DGW    = $clog2(MAX_DEGREE + 1);
  localparam int ADJ_D  = MAX_VERTICES * MAX_DEGREE;
  localparam int ADJ_AW = $clog2(ADJ_D);
  localparam int CW     = $clog2(MAX_VERTICES + 1);
  localparam int JW     = VW + WEIGHT_BITS;
  localparam int OW     = VW + DB;
  localparam int NW     = DB + PARW + 1;
  localparam logic [DB-1:0]  DIST_INF = {DB{1'b1}};
  localparam logic [VCW-1:0] MAXV_VC  = VCW'(MAX_VERTICES);
  localparam logic [DGW-1:0] MAXD_DG  = DGW'(MAX_DEGREE);
  localparam logic [CW-1:0]  MAXV_CNT = CW'(MAX_VERTICES);

  fsm_t state_r, state_nxt;

  logic [VCW-1:0]         vc_r, vc_nxt;
  logic [VW-1:0]          a_r, a_nxt, b_r, b_nxt;
  logic [WEIGHT_BITS-1:0] w_r, w_nxt;
  logic [STW-1:0]         ldst_r, ldst_nxt;
  logic                   side_r, side_nxt;
  logic [DGW-1:0]         dg_r [2];
  logic [DGW-1:0]         dg_nxt [2];
  logic                   fnd_r [2];
  logic                   fnd_nxt [2];
  logic [DGW-1:0]         slot_r [2];
  logic [DGW-1:0]         slot_nxt [2];
  logic [DGW-1:0]         pos_r [2];
  logic [DGW-1:0]         pos_nxt [2];
  logic                   posset_r, posset_nxt;
  logic [DGW-1:0]         k_r, k_nxt, j_r, j_nxt, dcur_r, dcur_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt, oi_r, oi_nxt, oj_r, oj_nxt, pcnt_r, pcnt_nxt;
  logic                   rfound_r, rfound_nxt;
  logic [VW-1:0]          cur_r, cur_nxt, nb_r, nb_nxt, pv_r, pv_nxt;
  logic [DB-1:0]          curd_r, curd_nxt, total_r, total_nxt;
  logic [WEIGHT_BITS-1:0] wt_r, wt_nxt;
  logic                   deg_rv_r, node_rv_r;
  logic [MAX_VERTICES-1:0] deg_vld_r, deg_vld_nxt, node_vld_r, node_vld_nxt;

  logic              adj_we, adj_re;
  logic [VA-1:0]     adj_v;
  logic [DGW-1:0]    adj_k, adj_wk;
  logic [ADJ_AW-1:0] adj_raddr, adj_waddr;
  logic [JW-1:0]     adj_wdata, adj_rdata;
  logic              deg_we, deg_re;
  logic [VA-1:0]     deg_waddr, deg_raddr;
  logic [DGW-1:0]    deg_wdata, deg_rdata;
  logic              node_we, node_re;
  logic [VA-1:0]     node_waddr, node_raddr;
  logic [NW-1:0]     node_wdata, node_rdata;
  logic              open_we, open_re;
  logic [VA-1:0]     open_waddr, open_raddr;
  logic [OW-1:0]     open_wdata, open_rdata;

  logic              emit, ob_ready;
  res_t              emit_data;
  logic              in_acc, cfg_wr;
  logic [VCW-1:0]    nlim;
  logic [VW-1:0]     sv_v, sv_nb;
  logic [VW-1:0]     adj_rv;
  logic [WEIGHT_BITS-1:0] adj_rw;
  logic [DB-1:0]     nd_dist;
  logic [PARW-1:0]   nd_par;
  logic              nd_closed;
  logic [DB:0]       sum;
  logic [DB-1:0]     total;
  logic [PARW-1:0]   pth_par;
  logic              pth_last;
  logic              a_eq_b;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_VERTEX_CNT);
  assign prdata   = (paddr[2] == REG_VERTEX_CNT) ? CFG_DW'(vc_r) : '0;
  assign nlim     = (vc_r > MAXV_VC) ? MAXV_VC : vc_r;
  assign a_eq_b   = (a_r == b_r);
  assign sv_v     = side_r ? b_r : a_r;
  assign sv_nb    = side_r ? a_r : b_r;
  assign adj_rv   = adj_rdata[JW-1 -: VW];
  assign adj_rw   = adj_rdata[WEIGHT_BITS-1:0];
  assign nd_dist   = node_rv_r ? node_rdata[NW-1 -: DB] : DIST_INF;
  assign nd_par    = node_rv_r ? node_rdata[PARW:1] : PARENT_NONE;
  assign nd_closed = node_rv_r && node_rdata[0];
  assign sum      = {1'b0, curd_r} + (DB+1)'(wt_r);
  assign total    = sum[DB] ? DIST_INF : sum[DB-1:0];
  assign pth_par  = nd_par;
  assign pth_last = (pth_par == PARENT_NONE) || (pth_par >= PARW'(MAX_VERTICES)) ||
                    ((pcnt_r + CW'(1)) >= MAXV_CNT);
  assign adj_raddr = ADJ_AW'(adj_v) * ADJ_AW'(MAX_DEGREE) + ADJ_AW'(adj_k);
  assign adj_waddr = ADJ_AW'(adj_v) * ADJ_AW'(MAX_DEGREE) + ADJ_AW'(adj_wk);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (req_t'(in_req_type))
            REQ_LOAD: begin
              if ((in_vertex_a >= VW'(MAX_VERTICES - 1) + VW'(1) && MAX_VERTICES < 64) ||
                  (in_vertex_b >= VW'(MAX_VERTICES - 1) + VW'(1) && MAX_VERTICES < 64)) begin
                state_nxt = L_RES;
              end else begin
                state_nxt = L_DEGA;
              end
            end
            REQ_QUERY: begin
              if ({1'b0, in_vertex_a} >= nlim || {1'b0, in_vertex_b} >= nlim) begin
                state_nxt = Q_REJ;
              end else begin
                state_nxt = Q_INIT;
              end
            end
            REQ_CLEAR: state_nxt = C_RES;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      L_DEGA: state_nxt = L_DEGB;
      L_DEGB: state_nxt = L_DEGW;
      L_DEGW: state_nxt = L_SCAN;
      L_SCAN: begin
        if (k_r >= dg_r[side_r]) begin
          if (!side_r && !a_eq_b) begin
            state_nxt = L_SCAN;
          end else begin
            state_nxt = L_CHECK;
          end
        end else begin
          state_nxt = L_SCANW;
        end
      end
      L_SCANW: state_nxt = L_SCAN;
      L_CHECK: begin
        if ((!fnd_r[0] && dg_r[0] >= MAXD_DG) ||
            (!a_eq_b && !fnd_r[1] && dg_r[1] >= MAXD_DG)) begin
          state_nxt = L_RES;
        end else begin
          state_nxt = L_UPD;
        end
      end
      L_UPD: begin
        if (!fnd_r[side_r]) begin
          state_nxt = L_SHR;
        end else if (!side_r && !a_eq_b) begin
          state_nxt = L_UPD;
        end else begin
          state_nxt = L_RES;
        end
      end
      L_SHR: state_nxt = (j_r == pos_r[side_r]) ? L_PUT : L_SHW;
      L_SHW: state_nxt = L_SHR;
      L_PUT: state_nxt = (!side_r && !a_eq_b) ? L_UPD : L_RES;
      L_RES, C_RES, Q_REJ: state_nxt = ob_ready ? S_IDLE : state_r;
      Q_INIT: state_nxt = Q_POP;
      Q_POP:  state_nxt = (cnt_r == '0) ? P_RD : Q_POPW;
      Q_POPW: state_nxt = Q_CLOSE;
      Q_CLOSE: state_nxt = (cur_r == b_r) ? P_RD : Q_NB;
      Q_NB:   state_nxt = (k_r >= dcur_r) ? Q_POP : Q_NBW;
      Q_NBW:  state_nxt = ({1'b0, adj_rv} >= nlim) ? Q_NB : Q_REL;
      Q_REL: begin
        if (!nd_closed && total < nd_dist) begin
          state_nxt = (nd_par != PARENT_NONE) ? R_RD : I_RD;
        end else begin
          state_nxt = Q_NB;
        end
      end
      R_RD: state_nxt = (oi_r == cnt_r) ? I_RD : R_W;
      R_W:  state_nxt = R_RD;
      I_RD: begin
        if (cnt_r >= MAXV_CNT || oj_r == '0) begin
          state_nxt = Q_NB;
        end else begin
          state_nxt = I_W;
        end
      end
      I_W:    state_nxt = (total_r > open_rdata[DB-1:0]) ? I_RD : Q_NB;
      P_RD:   state_nxt = P_EMIT;
      P_EMIT: begin
        if (ob_ready) begin
          state_nxt = pth_last ? S_IDLE : P_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    vc_nxt = cfg_wr ? pwdata[VCW-1:0] : vc_r;
    a_nxt = a_r; b_nxt = b_r; w_nxt = w_r; ldst_nxt = ldst_r;
    side_nxt = side_r; posset_nxt = posset_r;
    dg_nxt = dg_r; fnd_nxt = fnd_r; slot_nxt = slot_r; pos_nxt = pos_r;
    k_nxt = k_r; j_nxt = j_r; dcur_nxt = dcur_r;
    cnt_nxt = cnt_r; oi_nxt = oi_r; oj_nxt = oj_r; pcnt_nxt = pcnt_r;
    rfound_nxt = rfound_r; cur_nxt = cur_r; nb_nxt = nb_r; pv_nxt = pv_r;
    curd_nxt = curd_r; total_nxt = total_r; wt_nxt = wt_r;
    deg_vld_nxt = deg_vld_r; node_vld_nxt = node_vld_r;
    adj_we = 1'b0; adj_re = 1'b0; adj_v = sv_v[VA-1:0]; adj_k = k_r; adj_wk = k_r;
    adj_wdata = {sv_nb, w_r};
    deg_we = 1'b0; deg_re = 1'b0; deg_waddr = sv_v[VA-1:0]; deg_raddr = a_r[VA-1:0];
    deg_wdata = dg_r[side_r] + DGW'(1);
    node_we = 1'b0; node_re = 1'b0; node_waddr = nb_r[VA-1:0]; node_raddr = pv_r[VA-1:0];
    node_wdata = {total, 1'b0, cur_r, 1'b0};
    open_we = 1'b0; open_re = 1'b0; open_waddr = oj_r[VA-1:0]; open_raddr = oi_r[VA-1:0];
    open_wdata = open_rdata;
    emit = 1'b0;
    emit_data = '{vertex: '0, status: ldst_r, last: 1'b1};
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          a_nxt = in_vertex_a;
          b_nxt = in_vertex_b;
          w_nxt = WEIGHT_BITS'(in_edge_weight);
          ldst_nxt = ST_DROPPED;
          node_vld_nxt = '0;
        end
      end
      L_DEGA: begin
        deg_re = 1'b1;
        deg_raddr = a_r[VA-1:0];
      end
      L_DEGB: begin
        dg_nxt[0] = deg_rv_r ? deg_rdata : '0;
        pos_nxt[0] = deg_rv_r ? deg_rdata : '0;
        deg_re = 1'b1;
        deg_raddr = b_r[VA-1:0];
      end
      L_DEGW: begin
        dg_nxt[1] = deg_rv_r ? deg_rdata : '0;
        pos_nxt[1] = deg_rv_r ? deg_rdata : '0;
        fnd_nxt[0] = 1'b0;
        fnd_nxt[1] = 1'b0;
        side_nxt = 1'b0;
        posset_nxt = 1'b0;
        k_nxt = '0;
      end
      L_SCAN: begin
        if (k_r >= dg_r[side_r]) begin
          if (!side_r && !a_eq_b) begin
            side_nxt = 1'b1;
            k_nxt = '0;
            posset_nxt = 1'b0;
          end
        end else begin
          adj_re = 1'b1;
        end
      end
      L_SCANW: begin
        if (adj_rv == sv_nb && !fnd_r[side_r]) begin
          fnd_nxt[side_r] = 1'b1;
          slot_nxt[side_r] = k_r;
        end
        if (adj_rv > sv_nb && !posset_r) begin
          posset_nxt = 1'b1;
          pos_nxt[side_r] = k_r;
        end
        k_nxt = k_r + DGW'(1);
      end
      L_CHECK: begin
        side_nxt = 1'b0;
        j_nxt = dg_r[0];
        if (!((!fnd_r[0] && dg_r[0] >= MAXD_DG) ||
              (!a_eq_b && !fnd_r[1] && dg_r[1] >= MAXD_DG))) begin
          ldst_nxt = ST_LOAD_OK;
        end
      end
      L_UPD: begin
        j_nxt = dg_r[side_r];
        if (fnd_r[side_r]) begin
          adj_we = 1'b1;
          adj_wk = slot_r[side_r];
          if (!side_r && !a_eq_b) begin
            side_nxt = 1'b1;
          end
        end
      end
      L_SHR: begin
        if (j_r != pos_r[side_r]) begin
          adj_re = 1'b1;
          adj_k = j_r - DGW'(1);
        end
      end
      L_SHW: begin
        adj_we = 1'b1;
        adj_wk = j_r;
        adj_wdata = adj_rdata;
        j_nxt = j_r - DGW'(1);
      end
      L_PUT: begin
        adj_we = 1'b1;
        adj_wk = pos_r[side_r];
        deg_we = 1'b1;
        deg_vld_nxt[sv_v[VA-1:0]] = 1'b1;
        if (!side_r && !a_eq_b) begin
          side_nxt = 1'b1;
        end
      end
      L_RES: begin
        emit = ob_ready;
      end
      C_RES: begin
        emit = ob_ready;
        emit_data.status = ST_CLEARED;
        if (ob_ready) begin
          deg_vld_nxt = '0;
          cnt_nxt = '0;
        end
      end
      Q_REJ: begin
        emit = ob_ready;
        emit_data.status = ST_REJECTED;
      end
      Q_INIT: begin
        node_we = 1'b1;
        node_waddr = a_r[VA-1:0];
        node_wdata = {{DB{1'b0}}, PARENT_NONE, 1'b0};
        node_vld_nxt[a_r[VA-1:0]] = 1'b1;
        open_we = 1'b1;
        open_waddr = '0;
        open_wdata = {a_r, {DB{1'b0}}};
        cnt_nxt = CW'(1);
      end
      Q_POP: begin
        pv_nxt = b_r;
        pcnt_nxt = '0;
        if (cnt_r != '0) begin
          open_re = 1'b1;
          open_raddr = VA'(cnt_r - CW'(1));
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      Q_POPW: begin
        cur_nxt = open_rdata[OW-1 -: VW];
        curd_nxt = open_rdata[DB-1:0];
        node_re = 1'b1;
        node_raddr = open_rdata[OW-1 -: VA];
        deg_re = 1'b1;
        deg_raddr = open_rdata[OW-1 -: VA];
      end
      Q_CLOSE: begin
        node_we = 1'b1;
        node_waddr = cur_r[VA-1:0];
        node_wdata = {nd_dist, nd_par, 1'b1};
        node_vld_nxt[cur_r[VA-1:0]] = 1'b1;
        dcur_nxt = deg_rv_r ? deg_rdata : '0;
        k_nxt = '0;
        pv_nxt = b_r;
        pcnt_nxt = '0;
      end
      Q_NB: begin
        pv_nxt = b_r;
        pcnt_nxt = '0;
        if (k_r < dcur_r) begin
          adj_re = 1'b1;
          adj_v = cur_r[VA-1:0];
        end
      end
      Q_NBW: begin
        nb_nxt = adj_rv;
        wt_nxt = adj_rw;
        if ({1'b0, adj_rv} >= nlim) begin
          k_nxt = k_r + DGW'(1);
        end else begin
          node_re = 1'b1;
          node_raddr = adj_rv[VA-1:0];
        end
      end
      Q_REL: begin
        total_nxt = total;
        oi_nxt = '0;
        oj_nxt = cnt_r;
        rfound_nxt = 1'b0;
        if (!nd_closed && total < nd_dist) begin
          node_we = 1'b1;
          node_vld_nxt[nb_r[VA-1:0]] = 1'b1;
        end else begin
          k_nxt = k_r + DGW'(1);
        end
      end
      R_RD: begin
        if (oi_r == cnt_r) begin
          if (rfound_r) begin
            cnt_nxt = cnt_r - CW'(1);
            oj_nxt = cnt_r - CW'(1);
          end else begin
            oj_nxt = cnt_r;
          end
        end else begin
          open_re = 1'b1;
        end
      end
      R_W: begin
        if (rfound_r) begin
          open_we = 1'b1;
          open_waddr = VA'(oi_r - CW'(1));
        end else if (open_rdata[OW-1 -: VW] == nb_r) begin
          rfound_nxt = 1'b1;
        end
        oi_nxt = oi_r + CW'(1);
      end
      I_RD: begin
        open_wdata = {nb_r, total_r};
        if (cnt_r >= MAXV_CNT) begin
          k_nxt = k_r + DGW'(1);
        end else if (oj_r == '0) begin
          open_we = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
          k_nxt = k_r + DGW'(1);
        end else begin
          open_re = 1'b1;
          open_raddr = VA'(oj_r - CW'(1));
        end
      end
      I_W: begin
        open_we = 1'b1;
        if (total_r > open_rdata[DB-1:0]) begin
          oj_nxt = oj_r - CW'(1);
        end else begin
          open_wdata = {nb_r, total_r};
          cnt_nxt = cnt_r + CW'(1);
          k_nxt = k_r + DGW'(1);
        end
      end
      P_RD: begin
        node_re = 1'b1;
      end
      P_EMIT: begin
        emit = ob_ready;
        emit_data = '{vertex: pv_r, status: ST_PATH, last: pth_last};
        if (ob_ready) begin
          pv_nxt = pth_par[VW-1:0];
          pcnt_nxt = pcnt_r + CW'(1);
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      vc_r       <= '0;
      cnt_r      <= '0;
      deg_vld_r  <= '0;
      node_vld_r <= '0;
    end else begin
      state_r    <= state_nxt;
      vc_r       <= vc_nxt;
      cnt_r      <= cnt_nxt;
      deg_vld_r  <= deg_vld_nxt;
      node_vld_r <= node_vld_nxt;
    end
    a_r <= a_nxt; b_r <= b_nxt; w_r <= w_nxt; ldst_r <= ldst_nxt;
    side_r <= side_nxt; posset_r <= posset_nxt;
    dg_r <= dg_nxt; fnd_r <= fnd_nxt; slot_r <= slot_nxt; pos_r <= pos_nxt;
    k_r <= k_nxt; j_r <= j_nxt; dcur_r <= dcur_nxt;
    oi_r <= oi_nxt; oj_r <= oj_nxt; pcnt_r <= pcnt_nxt; rfound_r <= rfound_nxt;
    cur_r <= cur_nxt; nb_r <= nb_nxt; pv_r <= pv_nxt;
    curd_r <= curd_nxt; total_r <= total_nxt; wt_r <= wt_nxt;
    if (deg_re) begin
      deg_rv_r <= deg_vld_r[deg_raddr];
    end
    if (node_re) begin
      node_rv_r <= node_vld_r[node_raddr];
    end
  end

  dsp_ram #(.WIDTH(JW), .DEPTH(ADJ_D)) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .re    (adj_re),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  dsp_ram #(.WIDTH(DGW), .DEPTH(MAX_VERTICES)) u_deg_ram (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr),
    .wdata (deg_wdata),
    .re    (deg_re),
    .raddr (deg_raddr),
    .rdata (deg_rdata)
  );

  dsp_ram #(.WIDTH(NW), .DEPTH(MAX_VERTICES)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .re    (node_re),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  dsp_ram #(.WIDTH(OW), .DEPTH(MAX_VERTICES)) u_open_ram (
    .clk   (clk),
    .we    (open_we),
    .waddr (open_waddr),
    .wdata (open_wdata),
    .re    (open_re),
    .raddr (open_raddr),
    .rdata (open_rdata)
  );

  dsp_out_buf u_out_buf (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (emit),
    .push_data       (emit_data),
    .ready           (ob_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_path_vertex (out_path_vertex),
    .out_status      (out_status),
    .out_last        (out_last)
  );

  a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAXV_CNT)
    else $error("open list count overflow");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_req_type != REQ_NONE) |=> in_stall)
    else $error("request accepted without leaving idle");

  a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !emit)
    else $error("result word pushed while idle");

endmodule

### sv/dsp_ram.sv
module dsp_ram
  import dsp_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/dsp_out_buf.sv
module dsp_out_buf
  import dsp_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  res_t            push_data,
  output logic            ready,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [VW-1:0]   out_path_vertex,
  output logic [STW-1:0]  out_status,
  output logic            out_last
);

  logic vld_r;
  logic vld_nxt;
  res_t data_r;

  assign ready = !vld_r || !out_stall;

  always_comb begin
    vld_nxt = vld_r && out_stall;
    if (push) begin
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (push) begin
      data_r <= push_data;
    end
  end

  assign out_valid       = vld_r;
  assign out_path_vertex = data_r.vertex;
  assign out_status      = data_r.status;
  assign out_last        = data_r.last;

endmodule
